// ===== sv/lks_pkg.sv =====
// Shared types, state codes and register map of the link keepalive supervisor.
package lks_pkg;

  typedef enum logic [3:0] {
    ST_WAIT  = 4'b0001,
    ST_AVAIL = 4'b0010,
    ST_CONN  = 4'b0100,
    ST_DISC  = 4'b1000
  } link_fsm_t;

  localparam logic [1:0] LINK_WAIT  = 2'd0;
  localparam logic [1:0] LINK_AVAIL = 2'd1;
  localparam logic [1:0] LINK_CONN  = 2'd2;
  localparam logic [1:0] LINK_DISC  = 2'd3;

  localparam int         CFG_ADDR_W      = 3;
  localparam logic       REG_WAIT_PERIOD = 1'b0;
  localparam logic       REG_CONN_PERIOD = 1'b1;
  localparam logic [15:0] PERIOD_RESET   = 16'd500;

  typedef struct packed {
    logic [15:0] wait_period;
    logic [15:0] conn_period;
  } lks_cfg_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic        ping_issued;
    logic        create_issued;
    logic        teardown_issued;
    logic        service_issued;
    logic        transport_up;
    logic        is_connected;
    logic [31:0] connections_total;
    logic [31:0] disconnects_total;
    logic [31:0] reconnects_total;
  } link_result_t;

  function automatic logic [1:0] link_code(link_fsm_t s);
    logic [1:0] code;
    unique case (s)
      ST_WAIT:  code = LINK_WAIT;
      ST_AVAIL: code = LINK_AVAIL;
      ST_CONN:  code = LINK_CONN;
      ST_DISC:  code = LINK_DISC;
      default:  code = LINK_WAIT;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/lks_tick_if.sv =====
// Tick channel: one beat carries the time and the ping and create answers.
interface lks_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        ping_reply;
  logic        create_ok;

  modport source (output valid, now_ms, ping_reply, create_ok, input ready);
  modport sink   (input valid, now_ms, ping_reply, create_ok, output ready);
endinterface

// ===== sv/lks_report_if.sv =====
// Report channel: one beat carries the link status after one tick.
interface lks_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  link_state;
  logic        ping_issued;
  logic        create_issued;
  logic        teardown_issued;
  logic        service_issued;
  logic        transport_up;
  logic        is_connected;
  logic [31:0] connections_total;
  logic [31:0] disconnects_total;
  logic [31:0] reconnects_total;

  modport source (output valid, link_state, ping_issued, create_issued, teardown_issued,
                  service_issued, transport_up, is_connected, connections_total,
                  disconnects_total, reconnects_total, input ready);
  modport sink   (input valid, link_state, ping_issued, create_issued, teardown_issued,
                  service_issued, transport_up, is_connected, connections_total,
                  disconnects_total, reconnects_total, output ready);
endinterface

// ===== sv/lks_cfg_regs.sv =====
// APB register block holding the two ping periods.
module lks_cfg_regs
  import lks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output lks_cfg_t              cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_period <= PERIOD_RESET;
      cfg.conn_period <= PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WAIT_PERIOD: cfg.wait_period <= pwdata[15:0];
        REG_CONN_PERIOD: cfg.conn_period <= pwdata[15:0];
        default:         cfg.wait_period <= cfg.wait_period;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WAIT_PERIOD: prdata = {16'd0, cfg.wait_period};
      REG_CONN_PERIOD: prdata = {16'd0, cfg.conn_period};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/lks_step.sv =====
// Next-state and report logic for one tick of the link supervisor.
module lks_step
  import lks_pkg::*;
#(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  link_fsm_t              fsm,
  input  logic [TIME_WIDTH-1:0]  last_wait,
  input  logic [TIME_WIDTH-1:0]  last_live,
  input  logic [COUNT_WIDTH-1:0] conn_cnt,
  input  logic [COUNT_WIDTH-1:0] disc_cnt,
  input  logic [COUNT_WIDTH-1:0] reconn_cnt,
  input  logic                   xport,
  input  lks_cfg_t               cfg,
  input  logic [TIME_WIDTH-1:0]  now,
  input  logic                   ping_reply,
  input  logic                   create_ok,
  output link_fsm_t              fsm_next,
  output logic [TIME_WIDTH-1:0]  last_wait_next,
  output logic [TIME_WIDTH-1:0]  last_live_next,
  output logic [COUNT_WIDTH-1:0] conn_cnt_next,
  output logic [COUNT_WIDTH-1:0] disc_cnt_next,
  output logic [COUNT_WIDTH-1:0] reconn_cnt_next,
  output logic                   xport_next,
  output link_result_t           res
);

  logic [TIME_WIDTH-1:0]  wait_elapsed;
  logic [TIME_WIDTH-1:0]  live_elapsed;
  logic                   wait_due;
  logic                   live_due;
  logic [COUNT_WIDTH-1:0] conn_inc;
  logic                   ping;
  logic                   made;
  logic                   down;
  logic                   serviced;

  // Elapsed time wraps with the time width.
  assign wait_elapsed = now - last_wait;
  assign live_elapsed = now - last_live;
  assign wait_due     = wait_elapsed >= TIME_WIDTH'(cfg.wait_period);
  assign live_due     = live_elapsed >= TIME_WIDTH'(cfg.conn_period);
  assign conn_inc     = conn_cnt + COUNT_WIDTH'(1);

  always_comb begin
    fsm_next        = fsm;
    last_wait_next  = last_wait;
    last_live_next  = last_live;
    conn_cnt_next   = conn_cnt;
    disc_cnt_next   = disc_cnt;
    reconn_cnt_next = reconn_cnt;
    xport_next      = xport;
    ping            = 1'b0;
    made            = 1'b0;
    down            = 1'b0;
    serviced        = 1'b0;
    unique case (fsm)
      ST_WAIT: begin
        if (wait_due) begin
          last_wait_next = now;
          ping           = 1'b1;
          if (ping_reply) fsm_next = ST_AVAIL;
        end
      end
      ST_AVAIL: begin
        made = 1'b1;
        if (create_ok) begin
          conn_cnt_next = conn_inc;
          // count a reconnect once the session count passes one
          if (conn_inc > COUNT_WIDTH'(1)) reconn_cnt_next = reconn_cnt + COUNT_WIDTH'(1);
          xport_next     = 1'b1;
          last_live_next = now;
          fsm_next       = ST_CONN;
        end else begin
          down       = 1'b1;
          xport_next = 1'b0;
          fsm_next   = ST_WAIT;
        end
      end
      ST_CONN: begin
        serviced = 1'b1;
        if (live_due) begin
          last_live_next = now;
          ping           = 1'b1;
          if (!ping_reply) begin
            disc_cnt_next = disc_cnt + COUNT_WIDTH'(1);
            xport_next    = 1'b0;
            fsm_next      = ST_DISC;
          end
        end
      end
      default: begin
        // disconnected: tear down and start waiting again
        down           = 1'b1;
        last_wait_next = now;
        fsm_next       = ST_WAIT;
      end
    endcase
  end

  always_comb begin
    res.link_state        = link_code(fsm_next);
    res.ping_issued       = ping;
    res.create_issued     = made;
    res.teardown_issued   = down;
    res.service_issued    = serviced;
    res.transport_up      = xport_next;
    res.is_connected      = (fsm_next == ST_CONN);
    res.connections_total = 32'(conn_cnt_next);
    res.disconnects_total = 32'(disc_cnt_next);
    res.reconnects_total  = 32'(reconn_cnt_next);
  end

endmodule

// ===== sv/link_keepalive_supervisor.sv =====
// Top level of the link keepalive supervisor: tick register, state, report register.
//
//   port     kind      role   beat contents
//   tick     stream in sink   now_ms, ping_reply, create_ok
//   report   stream out source link_state, issue flags, transport_up, counters
//   p*       APB       slave  waiting_ping_period (0x0), connected_ping_period (0x4)
//
// One tick per cycle while the report is not stalled: a tick enters the input register,
// is evaluated against the state registers and lands in the report register.
// report.valid rises when the report register takes the tick from the input register.
// A stalled report holds the input register; tick.ready drops only when both are full.
// Synchronous reset clears the state machine, counters and both valid bits.
module link_keepalive_supervisor
  import lks_pkg::*;
#(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  lks_tick_if.sink              tick,
  lks_report_if.source          report,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  lks_cfg_t cfg;

  // input register
  logic        in_valid;
  logic [31:0] in_now;
  logic        in_reply;
  logic        in_create;
  logic        advance;

  // supervisor state
  link_fsm_t              fsm;
  link_fsm_t              fsm_next;
  logic [TIME_WIDTH-1:0]  last_wait;
  logic [TIME_WIDTH-1:0]  last_wait_next;
  logic [TIME_WIDTH-1:0]  last_live;
  logic [TIME_WIDTH-1:0]  last_live_next;
  logic [COUNT_WIDTH-1:0] conn_cnt;
  logic [COUNT_WIDTH-1:0] conn_cnt_next;
  logic [COUNT_WIDTH-1:0] disc_cnt;
  logic [COUNT_WIDTH-1:0] disc_cnt_next;
  logic [COUNT_WIDTH-1:0] reconn_cnt;
  logic [COUNT_WIDTH-1:0] reconn_cnt_next;
  logic                   xport;
  logic                   xport_next;

  link_result_t step_res;
  link_result_t out_res;
  logic         out_valid;

  lks_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lks_step #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .fsm             (fsm),
    .last_wait       (last_wait),
    .last_live       (last_live),
    .conn_cnt        (conn_cnt),
    .disc_cnt        (disc_cnt),
    .reconn_cnt      (reconn_cnt),
    .xport           (xport),
    .cfg             (cfg),
    .now             (TIME_WIDTH'(in_now)),
    .ping_reply      (in_reply),
    .create_ok       (in_create),
    .fsm_next        (fsm_next),
    .last_wait_next  (last_wait_next),
    .last_live_next  (last_live_next),
    .conn_cnt_next   (conn_cnt_next),
    .disc_cnt_next   (disc_cnt_next),
    .reconn_cnt_next (reconn_cnt_next),
    .xport_next      (xport_next),
    .res             (step_res)
  );

  // Move the held tick into the report register when that register frees up.
  assign advance    = in_valid & (~out_valid | report.ready);
  assign tick.ready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid & tick.ready) begin
      in_now    <= tick.now_ms;
      in_reply  <= tick.ping_reply;
      in_create <= tick.create_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= ST_WAIT;
      last_wait  <= '0;
      last_live  <= '0;
      conn_cnt   <= '0;
      disc_cnt   <= '0;
      reconn_cnt <= '0;
      xport      <= 1'b0;
    end else if (advance) begin
      fsm        <= fsm_next;
      last_wait  <= last_wait_next;
      last_live  <= last_live_next;
      conn_cnt   <= conn_cnt_next;
      disc_cnt   <= disc_cnt_next;
      reconn_cnt <= reconn_cnt_next;
      xport      <= xport_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign report.valid             = out_valid;
  assign report.link_state        = out_res.link_state;
  assign report.ping_issued       = out_res.ping_issued;
  assign report.create_issued     = out_res.create_issued;
  assign report.teardown_issued   = out_res.teardown_issued;
  assign report.service_issued    = out_res.service_issued;
  assign report.transport_up      = out_res.transport_up;
  assign report.is_connected      = out_res.is_connected;
  assign report.connections_total = out_res.connections_total;
  assign report.disconnects_total = out_res.disconnects_total;
  assign report.reconnects_total  = out_res.reconnects_total;

endmodule

// ===== sv/lks_checker.sv =====
// Port-level checks on the link supervisor report stream, bound to the top level.
module lks_checker
  import lks_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [1:0] link_state,
  input logic       ping_issued,
  input logic       create_issued,
  input logic       teardown_issued,
  input logic       service_issued,
  input logic       transport_up,
  input logic       is_connected
);

  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(link_state) && $stable(transport_up))
    else $error("report beat changed while stalled");

  a_conn_flag: assert property (@(posedge clk) disable iff (rst)
    valid && is_connected |-> transport_up && link_state == LINK_CONN)
    else $error("connected report without transport flag");

  a_create_alone: assert property (@(posedge clk) disable iff (rst)
    valid && create_issued |-> !ping_issued && !service_issued)
    else $error("session create mixed with ping or service");

  a_teardown_wait: assert property (@(posedge clk) disable iff (rst)
    valid && teardown_issued |-> link_state == LINK_WAIT && !service_issued)
    else $error("teardown not followed by waiting state");

endmodule

bind link_keepalive_supervisor lks_checker u_lks_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (report.valid),
  .ready           (report.ready),
  .link_state      (report.link_state),
  .ping_issued     (report.ping_issued),
  .create_issued   (report.create_issued),
  .teardown_issued (report.teardown_issued),
  .service_issued  (report.service_issued),
  .transport_up    (report.transport_up),
  .is_connected    (report.is_connected)
);

// ===== tb/sv/tb.sv =====
// Testbench for the link keepalive supervisor: tick stimulus, APB setup, status predictor.
`timescale 1ns / 1ps

module tb;
  import lks_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int REPORT_CAP  = 100;

  // Tracks the supervisor's state and queues the status each tick should produce.
  class keepalive_tracker;
    logic [1:0]   fsm;
    logic [31:0]  last_wait;
    logic [31:0]  last_live;
    logic [31:0]  n_conn;
    logic [31:0]  n_disc;
    logic [31:0]  n_reconn;
    logic         up;
    logic [15:0]  wait_period;
    logic [15:0]  conn_period;
    link_result_t pending_status[$];
    int           errors;

    function new();
      fsm         = LINK_WAIT;
      last_wait   = '0;
      last_live   = '0;
      n_conn      = '0;
      n_disc      = '0;
      n_reconn    = '0;
      up          = 1'b0;
      wait_period = PERIOD_RESET;
      conn_period = PERIOD_RESET;
      errors      = 0;
    endfunction

    function void set_period(logic sel, logic [15:0] value);
      if (sel == REG_WAIT_PERIOD) begin
        wait_period = value;
      end else begin
        conn_period = value;
      end
    endfunction

    function int pending();
      return pending_status.size();
    endfunction

    function void note_tick(logic [31:0] now, logic reply, logic create);
      link_result_t r;
      logic [31:0]  since;
      r = '0;
      case (fsm)
        LINK_WAIT: begin
          since = now - last_wait;
          if (since >= {16'd0, wait_period}) begin
            last_wait     = now;
            r.ping_issued = 1'b1;
            if (reply) fsm = LINK_AVAIL;
          end
        end
        LINK_AVAIL: begin
          r.create_issued = 1'b1;
          if (create) begin
            n_conn = n_conn + 1;
            if (n_conn > 1) n_reconn = n_reconn + 1;
            up        = 1'b1;
            last_live = now;
            fsm       = LINK_CONN;
          end else begin
            r.teardown_issued = 1'b1;
            up                = 1'b0;
            fsm               = LINK_WAIT;
          end
        end
        LINK_CONN: begin
          r.service_issued = 1'b1;
          since = now - last_live;
          if (since >= {16'd0, conn_period}) begin
            last_live     = now;
            r.ping_issued = 1'b1;
            if (!reply) begin
              n_disc = n_disc + 1;
              up     = 1'b0;
              fsm    = LINK_DISC;
            end
          end
        end
        default: begin
          r.teardown_issued = 1'b1;
          last_wait         = now;
          fsm               = LINK_WAIT;
        end
      endcase
      r.link_state        = fsm;
      r.transport_up      = up;
      r.is_connected      = (fsm == LINK_CONN);
      r.connections_total = n_conn;
      r.disconnects_total = n_disc;
      r.reconnects_total  = n_reconn;
      pending_status.push_back(r);
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        if (errors < REPORT_CAP) $error("%s: expected %0h, got %0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_report(link_result_t got);
      link_result_t want;
      if (pending_status.size() == 0) begin
        if (errors < REPORT_CAP) $error("report beat with no tick outstanding");
        errors++;
        return;
      end
      want = pending_status.pop_front();
      match("link_state", want.link_state, got.link_state);
      match("ping_issued", want.ping_issued, got.ping_issued);
      match("create_issued", want.create_issued, got.create_issued);
      match("teardown_issued", want.teardown_issued, got.teardown_issued);
      match("service_issued", want.service_issued, got.service_issued);
      match("transport_up", want.transport_up, got.transport_up);
      match("is_connected", want.is_connected, got.is_connected);
      match("connections_total", want.connections_total, got.connections_total);
      match("disconnects_total", want.disconnects_total, got.disconnects_total);
      match("reconnects_total", want.reconnects_total, got.reconnects_total);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  lks_tick_if   tick_ch ();
  lks_report_if report_ch ();

  keepalive_tracker board;
  link_result_t     got;
  logic [31:0]      clock_ms;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_asked;
  int               hold_seen;
  int               hold_left;

  link_keepalive_supervisor dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .report  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      report_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      report_ch.ready <= 1'b0;
      hold_left       <= HOLD_CYCLES;
      hold_seen       <= hold_asked;
    end else begin
      report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      got = {report_ch.link_state, report_ch.ping_issued, report_ch.create_issued,
             report_ch.teardown_issued, report_ch.service_issued, report_ch.transport_up,
             report_ch.is_connected, report_ch.connections_total,
             report_ch.disconnects_total, report_ch.reconnects_total};
      board.check_report(got);
    end
  end

  task automatic send_tick(input logic [31:0] now, input logic reply, input logic create);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.now_ms     <= now;
    tick_ch.ping_reply <= reply;
    tick_ch.create_ok  <= create;
    do @(posedge clk); while (!tick_ch.ready);
    board.note_tick(now, reply, create);
    @(negedge clk);
  endtask

  // Drain the block, then do one APB write.
  task automatic write_reg(input logic sel, input logic [15:0] value);
    tick_ch.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (3) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_period(sel, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] wait_p, input logic [15:0] conn_p,
                           input int n, input int idle, input int stall, input int span,
                           input int hold_at, input int pause_at);
    int k;
    write_reg(REG_WAIT_PERIOD, wait_p);
    write_reg(REG_CONN_PERIOD, conn_p);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_asked++;
      if (i == pause_at) begin
        tick_ch.valid <= 1'b0;
        do @(negedge clk); while (board.pending() != 0);
      end
      // Mostly small steps around the periods; sometimes a repeat, a jump or a wrap.
      k = $urandom_range(99);
      if (k < 70) begin
        clock_ms = clock_ms + $urandom_range(span, 0);
      end else if (k < 94 && k >= 82) begin
        clock_ms = clock_ms + $urandom;
      end else if (k >= 94) begin
        clock_ms = $urandom;
      end
      send_tick(clock_ms, $urandom_range(99) < 85, $urandom_range(99) < 70);
    end
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.now_ms     = '0;
    tick_ch.ping_reply = 1'b0;
    tick_ch.create_ok  = 1'b0;
    report_ch.ready    = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_asked         = 0;
    hold_seen          = 0;
    hold_left          = 0;
    clock_ms           = '0;
    board              = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset periods: ping timing, create failure and success, loss, reconnect, time wrap.
    send_tick(32'd0, 1'b1, 1'b1);
    send_tick(32'd499, 1'b1, 1'b0);
    send_tick(32'd500, 1'b0, 1'b1);
    send_tick(32'd1000, 1'b1, 1'b0);
    send_tick(32'd1000, 1'b0, 1'b0);
    send_tick(32'd1500, 1'b1, 1'b1);
    send_tick(32'd1500, 1'b0, 1'b1);
    send_tick(32'd1999, 1'b0, 1'b0);
    send_tick(32'd2000, 1'b1, 1'b0);
    send_tick(32'd2500, 1'b0, 1'b1);
    send_tick(32'd2600, 1'b1, 1'b1);
    send_tick(32'd3100, 1'b1, 1'b0);
    send_tick(32'd3100, 1'b1, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_tick(32'h0000_01F3, 1'b1, 1'b0);
    send_tick(32'h0000_03E7, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_tick(32'h0000_01F3, 1'b1, 1'b1);
    send_tick(32'h0000_01F3, 1'b1, 1'b0);

    // Zero periods: a ping falls due on every tick in the waiting and connected states.
    write_reg(REG_WAIT_PERIOD, 16'd0);
    write_reg(REG_CONN_PERIOD, 16'd0);
    send_tick(32'h0000_01F3, 1'b0, 1'b0);
    send_tick(32'h0000_01F3, 1'b1, 1'b0);
    send_tick(32'h0000_01F3, 1'b0, 1'b1);
    send_tick(32'h0000_01F3, 1'b1, 1'b0);
    send_tick(32'h0000_01F3, 1'b0, 1'b0);
    send_tick(32'h0000_01F3, 1'b1, 1'b1);
    clock_ms = 32'h0000_01F3;

    run_phase(16'd1, 16'd1, 220, 0, 0, 3, -1, -1);
    run_phase(16'd65535, 16'd65535, 200, 59, 0, 140000, -1, -1);
    run_phase(16'd7, 16'd13, 260, 0, 59, 30, 40, -1);
    run_phase(16'd300, 16'd40, 260, 12, 12, 700, 100, 150);
    run_phase(16'd0, 16'd3, 200, 59, 0, 8, -1, -1);
    run_phase(PERIOD_RESET, PERIOD_RESET, 300, 12, 12, 1200, 50, 200);

    tick_ch.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (20) @(negedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
